>>> sv/pli_pkg.sv
package pli_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;
  localparam int unsigned IndexW = 4;

  // Default size of the breakpoint tables.
  localparam int unsigned MaxPointsDef = 16;

  // Region codes reported with every result.
  localparam logic [1:0] RegionInterp   = 2'd0;
  localparam logic [1:0] RegionBelow    = 2'd1;
  localparam logic [1:0] RegionPast     = 2'd2;
  localparam logic [1:0] RegionIdentity = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StCompare,
    StSetup,
    StAbs,
    StMul,
    StDiv,
    StAdd,
    StFinish
  } pli_state_e;

endpackage

>>> sv/piecewise_linear_interp_core.sv
// Piecewise-linear function lookup over a breakpoint table, signed Q16.16.
// Input channel (in_valid_i / in_stall_o): a word with mode_i low stores the
// breakpoint (point_x_i, point_y_i) in slot point_index_i and gives no result;
// a word with mode_i high evaluates the function at x_in_i and gives one word
// on the output channel (out_valid_o / out_stall_i) with y_out_o and region_o.
// The configuration channel (cfg_valid_i / cfg_ready_o) sets the number of
// breakpoints in use; it is always ready. It is to be written only while
// idle; the block itself does not enforce this. An evaluate searches the
// table with one table read and one compare for each visited breakpoint;
// when it interpolates it then runs set-up, a bit-serial multiply and a
// restoring divide, each with one narrow adder, and the final saturating add.
// An empty table returns without a search, and a result outside the table
// after the search alone. One word is worked on at a time; in_stall_o
// is high from acceptance until the result enters the output register.
// The output register holds a finished word while out_stall_i is high; the
// block then takes the next input word but holds its own result back until
// the register is free. Reset clears the breakpoint count to zero (identity
// mapping) and empties the output register; the tables are not cleared.
module piecewise_linear_interp_core #(
  parameter int unsigned MAX_POINTS = pli_pkg::MaxPointsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pli_pkg::CountW-1:0]   cfg_point_count_i,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [pli_pkg::IndexW-1:0]   point_index_i,
  input  logic signed [pli_pkg::DataW-1:0] point_x_i,
  input  logic signed [pli_pkg::DataW-1:0] point_y_i,
  input  logic signed [pli_pkg::DataW-1:0] x_in_i,
  // Output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [pli_pkg::DataW-1:0] y_out_o,
  output logic [1:0]                   region_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [8:0]  MaxP = 9'(MAX_POINTS);
  localparam int unsigned CW = pli_pkg::CountW;
  localparam int unsigned DW = pli_pkg::DataW;

  pli_pkg::pli_state_e state_q, state_d;

  logic [CW-1:0]  count_q;
  logic [CW-1:0]  n_eff;
  logic [CW-1:0]  n_q;
  logic [CW-1:0]  idx_q;
  logic [4:0]     step_q;

  logic [DW-1:0]  x_q;
  logic [DW-1:0]  x0_q;
  logic [DW-1:0]  y0_q;
  logic [DW-1:0]  rd_x_q;
  logic [DW-1:0]  rd_y_q;
  logic [DW:0]    dy_q;
  logic [DW-1:0]  mplier_q;
  logic [DW-1:0]  mcand_q;
  logic [DW-1:0]  den_q;
  logic [DW-1:0]  hi_q;
  logic [DW-1:0]  lo_q;
  logic           neg_q;

  logic [DW-1:0]  res_y_q;
  logic [1:0]     res_region_q;

  logic           out_valid_q;
  logic [DW-1:0]  out_y_q;
  logic [1:0]     out_region_q;

  logic           accept;
  logic           load_ok;
  logic           rd_en;
  logic           hit;
  logic           last;
  logic           out_load;
  logic [DW:0]    mul_sum;
  logic [DW+1:0]  div_diff;
  logic           div_ge;
  logic [DW+1:0]  add_sum;
  logic [DW-1:0]  sat_y;

  // Breakpoint tables.
  logic [DW-1:0]  x_mem [MAX_POINTS];
  logic [DW-1:0]  y_mem [MAX_POINTS];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != pli_pkg::StIdle);
  assign accept      = in_valid_i && !in_stall_o;

  // Breakpoints in use, limited to the table size.
  assign n_eff   = ({4'b0, count_q} > MaxP) ? MaxP[CW-1:0] : count_q;
  assign load_ok = ({5'b0, point_index_i} < MaxP);

  // Scan compare and end-of-table test.
  assign hit  = $signed(x_q) < $signed(rd_x_q);
  assign last = (CW'(idx_q + 1'b1) == n_q);

  // One step of the LSB-first shift-and-add multiply.
  assign mul_sum = {1'b0, hi_q} + (mplier_q[0] ? {1'b0, mcand_q} : '0);

  // One step of the restoring divide; the remainder stays below the divisor.
  assign div_diff = {1'b0, hi_q, lo_q[DW-1]} - {2'b0, den_q};
  assign div_ge   = !div_diff[DW+1];

  // Final signed sum of the lower ordinate and the quotient, with saturation.
  assign add_sum = neg_q ? ({{2{y0_q[DW-1]}}, y0_q} - {2'b0, lo_q})
                         : ({{2{y0_q[DW-1]}}, y0_q} + {2'b0, lo_q});
  always_comb begin
    if (add_sum[DW+1:DW-1] == 3'b000 || add_sum[DW+1:DW-1] == 3'b111) begin
      sat_y = add_sum[DW-1:0];
    end else if (add_sum[DW+1]) begin
      sat_y = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat_y = {1'b0, {(DW-1){1'b1}}};
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_point_count_i;
    end
  end

  // Table write on a load word, registered read during the scan.
  always_ff @(posedge clk_i) begin
    if (accept && !mode_i && load_ok) begin
      x_mem[AW'(point_index_i)] <= point_x_i;
      y_mem[AW'(point_index_i)] <= point_y_i;
    end
    if (rd_en) begin
      rd_x_q <= x_mem[AW'(idx_q)];
      rd_y_q <= y_mem[AW'(idx_q)];
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pli_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and control.
  always_comb begin
    state_d  = state_q;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      pli_pkg::StIdle: begin
        if (accept && mode_i) begin
          state_d = (n_eff == '0) ? pli_pkg::StFinish : pli_pkg::StRead;
        end
      end
      pli_pkg::StRead: begin
        rd_en   = 1'b1;
        state_d = pli_pkg::StCompare;
      end
      pli_pkg::StCompare: begin
        if (hit) begin
          state_d = (idx_q == '0) ? pli_pkg::StFinish : pli_pkg::StSetup;
        end else begin
          state_d = last ? pli_pkg::StFinish : pli_pkg::StRead;
        end
      end
      pli_pkg::StSetup: state_d = pli_pkg::StAbs;
      pli_pkg::StAbs:   state_d = pli_pkg::StMul;
      pli_pkg::StMul: begin
        if (step_q == 5'd31) begin
          state_d = pli_pkg::StDiv;
        end
      end
      pli_pkg::StDiv: begin
        if (step_q == 5'd31) begin
          state_d = pli_pkg::StAdd;
        end
      end
      pli_pkg::StAdd: state_d = pli_pkg::StFinish;
      pli_pkg::StFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = pli_pkg::StIdle;
        end
      end
      default: state_d = pli_pkg::StIdle;
    endcase
  end

  // Search and arithmetic datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      step_q <= '0;
      n_q    <= '0;
    end else begin
      unique case (state_q)
        pli_pkg::StIdle: begin
          idx_q  <= '0;
          step_q <= '0;
          n_q    <= n_eff;
        end
        pli_pkg::StCompare: begin
          if (!hit && !last) begin
            idx_q <= CW'(idx_q + 1'b1);
          end
        end
        pli_pkg::StMul, pli_pkg::StDiv: begin
          step_q <= 5'(step_q + 1'b1);
        end
        default: begin
          idx_q <= idx_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pli_pkg::StIdle: begin
        if (accept && mode_i) begin
          x_q          <= x_in_i;
          res_y_q      <= x_in_i;
          res_region_q <= pli_pkg::RegionIdentity;
        end
      end
      pli_pkg::StCompare: begin
        if (hit) begin
          // Below the first point; otherwise kept for the interpolation.
          res_y_q      <= rd_y_q;
          res_region_q <= pli_pkg::RegionBelow;
        end else begin
          x0_q         <= rd_x_q;
          y0_q         <= rd_y_q;
          res_y_q      <= rd_y_q;
          res_region_q <= pli_pkg::RegionPast;
        end
      end
      pli_pkg::StSetup: begin
        // The argument lies in [x0, x1), so both spans are non-negative.
        mplier_q <= DW'({x_q[DW-1], x_q} - {x0_q[DW-1], x0_q});
        den_q    <= DW'({rd_x_q[DW-1], rd_x_q} - {x0_q[DW-1], x0_q});
        dy_q     <= {rd_y_q[DW-1], rd_y_q} - {y0_q[DW-1], y0_q};
      end
      pli_pkg::StAbs: begin
        neg_q   <= dy_q[DW];
        mcand_q <= dy_q[DW] ? DW'(-dy_q) : dy_q[DW-1:0];
        hi_q    <= '0;
      end
      pli_pkg::StMul: begin
        hi_q     <= mul_sum[DW:1];
        lo_q     <= {mul_sum[0], lo_q[DW-1:1]};
        mplier_q <= {1'b0, mplier_q[DW-1:1]};
      end
      pli_pkg::StDiv: begin
        hi_q <= div_ge ? div_diff[DW-1:0] : {hi_q[DW-2:0], lo_q[DW-1]};
        lo_q <= {lo_q[DW-2:0], div_ge};
      end
      pli_pkg::StAdd: begin
        res_y_q      <= sat_y;
        res_region_q <= pli_pkg::RegionInterp;
      end
      default: begin
        res_y_q <= res_y_q;
      end
    endcase
  end

  // Output register: holds a finished word until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_y_q      <= res_y_q;
      out_region_q <= res_region_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign y_out_o     = out_y_q;
  assign region_o    = out_region_q;

endmodule

>>> dv/piecewise_linear_interp_core_tb.sv
`timescale 1ns / 1ps

module piecewise_linear_interp_core_tb;

  localparam int unsigned DataW = pli_pkg::DataW;
  localparam int unsigned CountW = pli_pkg::CountW;
  localparam int unsigned IndexW = pli_pkg::IndexW;
  localparam int unsigned MaxPoints = pli_pkg::MaxPointsDef;
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeEval = 1'b1;
  // Cycles to let a trailing load word settle before the count is changed.
  localparam int unsigned SettleCycles = 8;
  // Cycles without any accepted word before the run is abandoned.
  localparam int unsigned IdleLimit = 2000;
  localparam longint SatHi = 64'sd2147483647;
  localparam longint SatLo = -64'sd2147483648;

  typedef struct {
    logic signed [DataW-1:0] y;
    logic [1:0]              rgn;
  } curve_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CountW-1:0] cfg_point_count_i;
  logic in_valid_i;
  logic in_stall_o;
  logic mode_i;
  logic [IndexW-1:0] point_index_i;
  logic signed [DataW-1:0] point_x_i;
  logic signed [DataW-1:0] point_y_i;
  logic signed [DataW-1:0] x_in_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [DataW-1:0] y_out_o;
  logic [1:0] region_o;

  // Local copy of the breakpoint table and count, updated as words are accepted.
  logic signed [DataW-1:0] tab_x [MaxPoints];
  logic signed [DataW-1:0] tab_y [MaxPoints];
  int unsigned active_count = 0;
  curve_result_t pending_lookups [$];

  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit steady_source = 1'b0;
  bit steady_sink = 1'b0;

  piecewise_linear_interp_core #(
    .MAX_POINTS(MaxPoints)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_point_count_i(cfg_point_count_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .point_index_i    (point_index_i),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .x_in_i           (x_in_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .y_out_o          (y_out_o),
    .region_o         (region_o)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Linear interpolation on one segment: exact product, quotient truncated
  // toward zero, sum saturated to 32 bits.
  function automatic logic signed [DataW-1:0] interp_segment(input longint x,
      input longint x0, input longint y0, input longint x1, input longint y1);
    longint den, dx, dy, sum;
    logic [63:0] adx, ady, aden, q;
    bit neg;
    den = x1 - x0;
    dx = x - x0;
    dy = y1 - y0;
    if (den == 0) return y0[DataW-1:0];
    neg = ((dy < 0) != (dx < 0)) != (den < 0);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    aden = (den < 0) ? -den : den;
    q = (ady * adx) / aden;
    if (q > 64'hFF_FFFF_FFFF) q = 64'hFF_FFFF_FFFF;
    sum = neg ? y0 - longint'(q) : y0 + longint'(q);
    if (sum > SatHi) sum = SatHi;
    else if (sum < SatLo) sum = SatLo;
    return sum[DataW-1:0];
  endfunction

  // Function value at x for the current table and count.
  function automatic curve_result_t evaluate_curve(input logic signed [DataW-1:0] x);
    curve_result_t r;
    int unsigned n;
    bit hit;
    n = (active_count > MaxPoints) ? MaxPoints : active_count;
    if (n == 0) begin
      r.y = x;
      r.rgn = pli_pkg::RegionIdentity;
      return r;
    end
    r.y = tab_y[n-1];
    r.rgn = pli_pkg::RegionPast;
    hit = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!hit && x < tab_x[i]) begin
        hit = 1'b1;
        if (i == 0) begin
          r.y = tab_y[0];
          r.rgn = pli_pkg::RegionBelow;
        end else begin
          r.y = interp_segment(x, tab_x[i-1], tab_y[i-1], tab_x[i], tab_y[i]);
          r.rgn = pli_pkg::RegionInterp;
        end
      end
    end
    return r;
  endfunction

  // Argument for an evaluate word: anywhere, on or next to a breakpoint,
  // the extremes, or inside a segment.
  function automatic logic signed [DataW-1:0] pick_probe();
    int unsigned k;
    longint lo, hi, v;
    k = $urandom_range(0, MaxPoints - 2);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return tab_x[k];
      2: return tab_x[k] - 1;
      3: return tab_x[k] + 1;
      4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: begin
        lo = tab_x[k];
        hi = tab_x[k+1];
        if (hi <= lo) return $urandom();
        v = lo + longint'({32'd0, $urandom()}) % (hi - lo);
        return v[DataW-1:0];
      end
    endcase
  endfunction

  // Sends one word and updates the local table or queues the expected result.
  task automatic send_word(input logic m, input logic [IndexW-1:0] idx,
      input logic signed [DataW-1:0] px, input logic signed [DataW-1:0] py,
      input logic signed [DataW-1:0] xin);
    int unsigned gap;
    gap = steady_source ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= m;
    point_index_i <= idx;
    point_x_i <= px;
    point_y_i <= py;
    x_in_i <= xin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (m == ModeEval) begin
      pending_lookups.push_back(evaluate_curve(xin));
    end else begin
      tab_x[idx] = px;
      tab_y[idx] = py;
    end
  endtask

  task automatic load_point(input logic [IndexW-1:0] idx,
      input logic signed [DataW-1:0] px, input logic signed [DataW-1:0] py);
    send_word(ModeLoad, idx, px, py, $urandom());
  endtask

  task automatic eval_at(input logic signed [DataW-1:0] xin);
    send_word(ModeEval, IndexW'($urandom()), $urandom(), $urandom(), xin);
  endtask

  // Holds the input back until every expected result has come out.
  task automatic wait_for_results(input int unsigned settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Writes the breakpoint count once the block has gone idle.
  task automatic set_point_count(input logic [CountW-1:0] value);
    wait_for_results(SettleCycles);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_point_count_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    active_count = 32'(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Fills all slots: mostly ascending tables at a random scale, sometimes
  // with repeated abscissae, spanning the full range, or in no order at all.
  task automatic load_random_table();
    logic signed [DataW-1:0] xs [MaxPoints];
    longint base, acc;
    int unsigned step_max, style;
    style = $urandom_range(0, 9);
    step_max = 1 << $urandom_range(0, 27);
    base = SatLo + longint'({32'd0, $urandom()}) %
        (64'sd4294967296 - MaxPoints * longint'(step_max));
    acc = base;
    for (int i = 0; i < MaxPoints; i++) begin
      if (style == 0) begin
        xs[i] = $urandom();
      end else begin
        xs[i] = acc[DataW-1:0];
        if (!(style == 1 && $urandom_range(0, 2) == 0))
          acc = acc + $urandom_range(1, step_max);
      end
    end
    if (style == 2) begin
      xs[0] = 32'h8000_0000;
      xs[MaxPoints-1] = 32'h7FFF_FFFF;
    end
    for (int i = 0; i < MaxPoints; i++) begin
      load_point(IndexW'(i), xs[i],
          (style == 3) ? $urandom_range(0, 2000) - 1000 : $urandom());
    end
  endtask

  // With no breakpoints in use the argument comes back unchanged.
  task automatic test_empty_table();
    set_point_count(CountW'(0));
    eval_at(32'h8000_0000);
    eval_at(32'h7FFF_FFFF);
    eval_at(32'hFFFF_FFFF);
  endtask

  // Directed table, unit steps in x, with the extreme ordinates up front
  // and the largest abscissa in the top slot.
  task automatic test_table_fill();
    logic signed [DataW-1:0] ys [4];
    ys = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    for (int i = 0; i < MaxPoints; i++) begin
      load_point(IndexW'(i),
          (i == MaxPoints - 1) ? 32'h7FFF_FFFF : (i - 8) * 32'sh0001_0000,
          (i < 4) ? ys[i] : i * 32'sh0001_8000);
    end
    set_point_count(CountW'(MaxPoints));
  endtask

  // Below the table, on the first point, inside segments with the largest
  // span of ordinates and with truncation toward zero, and past the end.
  task automatic test_segments();
    eval_at(32'h8000_0000);
    eval_at(-32'sh0008_0000);
    eval_at(-32'sh0007_8000);
    eval_at(-32'sh0006_0000 + 1);
    eval_at(32'h7FFF_FFFF);
  endtask

  // Counts above the table size are clipped; one and two points.
  task automatic test_count_limits();
    set_point_count(CountW'(31));
    eval_at(32'h7FFF_FFFE);
    set_point_count(CountW'(17));
    eval_at(32'h0000_0000);
    set_point_count(CountW'(1));
    eval_at(32'h8000_0000);
    eval_at(32'h0000_0000);
    set_point_count(CountW'(2));
    eval_at(-32'sh0007_8000);
  endtask

  // One random phase: a new count, perhaps a fresh table, then a mix of
  // evaluate words and single-slot reloads, with a full drain half-way.
  task automatic test_random_phase(input int unsigned phase, input int unsigned words);
    logic [CountW-1:0] count_sel;
    case (phase % 8)
      0: count_sel = CountW'(16);
      1: count_sel = CountW'(0);
      2: count_sel = CountW'(1);
      3: count_sel = CountW'(31);
      4: count_sel = CountW'(2);
      5: count_sel = CountW'(17);
      default: count_sel = CountW'($urandom_range(3, 15));
    endcase
    set_point_count(count_sel);
    steady_source = (phase % 4 == 3);
    steady_sink = (phase % 4 == 3);
    if (phase % 2 == 0) load_random_table();
    for (int unsigned n = 0; n < words; n++) begin
      if (n == words / 2) wait_for_results(0);
      if ($urandom_range(0, 4) == 0)
        load_point(IndexW'($urandom_range(0, 15)), pick_probe(), $urandom());
      else eval_at(pick_probe());
    end
  endtask

  // Receiver stalls: a random stall, then a random run of free cycles.
  initial begin : sink_stall
    int unsigned n;
    out_stall_i = 1'b0;
    forever begin
      n = steady_sink ? 0 : pick_gap();
      repeat (n) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Each result word is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    curve_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result word, y_out %h region %0d", $time, y_out_o, region_o);
        fail_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (y_out_o !== want.y) begin
          $display("%0t: y_out mismatch, expected %h, actual %h", $time, want.y, y_out_o);
          fail_count++;
        end
        if (region_o !== want.rgn) begin
          $display("%0t: region mismatch, expected %0d, actual %0d", $time, want.rgn, region_o);
          fail_count++;
        end
      end
    end
  end

  // Abandons the run when no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_point_count_i = '0;
    in_valid_i = 1'b0;
    mode_i = ModeLoad;
    point_index_i = '0;
    point_x_i = '0;
    point_y_i = '0;
    x_in_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_table_fill();
    test_segments();
    test_count_limits();
    for (int unsigned p = 0; p < 12; p++) begin
      test_random_phase(p, 140);
    end

    wait_for_results(SettleCycles);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
